/* hw/rtl/print_layer_frame_trigger_assert.svh */
// assertion helpers for the print layer frame trigger
`ifndef PRINT_LAYER_FRAME_TRIGGER_ASSERT_SVH
`define PRINT_LAYER_FRAME_TRIGGER_ASSERT_SVH

// condition must never hold outside reset
`define PLFTRG_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PLFTRG_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/plftrg_pkg.sv */
package plftrg_pkg;

	// printer state codes
	localparam logic [2:0] ST_OTHER     = 3'd0;
	localparam logic [2:0] ST_PRINTING  = 3'd1;
	localparam logic [2:0] ST_PAUSED    = 3'd2;
	localparam logic [2:0] ST_ATTENTION = 3'd3;

	localparam logic [15:0] FRAMES_MAX = 16'hFFFF;

	// register indexes
	typedef enum logic [2:0] {
		REG_TRIGGER_ON_PRINT    = 3'd0,
		REG_UPLOAD_FOLLOW_PRINT = 3'd1,
		REG_LAYER_FRAME_MODE    = 3'd2,
		REG_Z_MIN_UM            = 3'd3,
		REG_Z_MAX_UM            = 3'd4,
		REG_CONFIRM_TOL_UM      = 3'd5,
		REG_MAX_JUMP_UM         = 3'd6,
		REG_LAYER_DELTA_UM      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]         printer_state;
		logic               z_present;
		logic signed [19:0] z_um;
		logic               recording;
	} sample_t;

	typedef struct packed {
		logic               start_timelapse;
		logic               stop_timelapse;
		logic               upload_on;
		logic               upload_off;
		logic               frame_trigger;
		logic               rebaselined;
		logic [15:0]        frame_count;
		logic signed [19:0] peak_layer_z_um;
	} result_t;

	typedef struct packed {
		logic               trigger_on_print;
		logic               upload_follow_print;
		logic               layer_frame_mode;
		logic signed [19:0] z_min_um;
		logic signed [19:0] z_max_um;
		logic [15:0]        confirm_tol_um;
		logic [18:0]        max_jump_um;
		logic [15:0]        layer_delta_um;
	} cfg_t;

endpackage

/* hw/rtl/print_layer_frame_trigger.sv */
// Print layer frame trigger: takes one printer status sample per beat and returns
// exactly one result beat with timelapse/upload pulses, the layer frame pulse, the
// session frame count and the peak layer Z. A sample can be accepted every clock while
// result_ready does not stall a full result register; the input register feeds
// the compare/add pass on the tracker state into the result register. Configuration
// writes are taken with cfg_ready always high and must only be issued while no
// sample is in flight; a write to layer_frame_mode drops the pending and baseline Z.
`include "print_layer_frame_trigger_assert.svh"

module print_layer_frame_trigger (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  plftrg_pkg::sample_t    sample,
	output logic                   result_valid,
	input  logic                   result_ready,
	output plftrg_pkg::result_t    result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  plftrg_pkg::reg_idx_t   cfg_index,
	input  logic [19:0]            cfg_data
);

	logic                 valid_s1;
	plftrg_pkg::sample_t  sample_s1;
	logic                 advance;
	logic                 res_valid_q;
	plftrg_pkg::result_t  res_q;
	plftrg_pkg::result_t  step_res;
	plftrg_pkg::cfg_t     cfg;
	logic                 mode_clr;
	logic                 res_rebase, res_frame, res_begin, res_end;

	assign cfg_ready = 1'b1;

	plftrg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.mode_clr (mode_clr)
	);

	// input register moves on when the result register is free
	assign advance      = valid_s1 && (!res_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
	end

	plftrg_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.smp      (sample_s1),
		.cfg      (cfg),
		.mode_clr (mode_clr),
		.res      (step_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// checks
	assign res_rebase = result_valid && result.rebaselined;
	assign res_frame  = result_valid && result.frame_trigger;
	assign res_begin  = result_valid && (result.start_timelapse || result.upload_on);
	assign res_end    = result_valid && (result.stop_timelapse || result.upload_off);

	`PLFTRG_IMPLY(a_rebase_frame, res_rebase, result.frame_trigger, "rebaselined without frame")
	`PLFTRG_IMPLY(a_frame_count, res_frame, result.frame_count != 16'd0, "frame with zero count")
	`PLFTRG_NEVER(a_start_end, res_begin && res_end, "start and end pulses together")

endmodule

/* hw/rtl/plftrg_cfg.sv */
module plftrg_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  plftrg_pkg::reg_idx_t  wr_index,
	input  logic [19:0]           wr_data,
	output plftrg_pkg::cfg_t      cfg,
	output logic                  mode_clr
);

	plftrg_pkg::cfg_t cfg_q;

	// register file with documented reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_on_print    <= 1'b0;
			cfg_q.upload_follow_print <= 1'b0;
			cfg_q.layer_frame_mode    <= 1'b0;
			cfg_q.z_min_um            <= -20'sd10000;
			cfg_q.z_max_um            <= 20'sd400000;
			cfg_q.confirm_tol_um      <= 16'd10;
			cfg_q.max_jump_um         <= 19'd5000;
			cfg_q.layer_delta_um      <= 16'd100;
		end else if (wr_en) begin
			case (wr_index)
				plftrg_pkg::REG_TRIGGER_ON_PRINT:    cfg_q.trigger_on_print    <= wr_data[0];
				plftrg_pkg::REG_UPLOAD_FOLLOW_PRINT: cfg_q.upload_follow_print <= wr_data[0];
				plftrg_pkg::REG_LAYER_FRAME_MODE:    cfg_q.layer_frame_mode    <= wr_data[0];
				plftrg_pkg::REG_Z_MIN_UM:            cfg_q.z_min_um       <= $signed(wr_data);
				plftrg_pkg::REG_Z_MAX_UM:            cfg_q.z_max_um       <= $signed(wr_data);
				plftrg_pkg::REG_CONFIRM_TOL_UM:      cfg_q.confirm_tol_um <= wr_data[15:0];
				plftrg_pkg::REG_MAX_JUMP_UM:         cfg_q.max_jump_um    <= wr_data[18:0];
				plftrg_pkg::REG_LAYER_DELTA_UM:      cfg_q.layer_delta_um <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg      = cfg_q;
	// a mode write drops the layer tracking history
	assign mode_clr = wr_en && (wr_index == plftrg_pkg::REG_LAYER_FRAME_MODE);

endmodule

/* hw/rtl/plftrg_track.sv */
module plftrg_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  plftrg_pkg::sample_t   smp,
	input  plftrg_pkg::cfg_t      cfg,
	input  logic                  mode_clr,
	output plftrg_pkg::result_t   res
);

	// tracker state
	logic [1:0]         prev_state_q;
	logic               prev_seen_q;
	logic signed [19:0] pend_z_q;
	logic               pend_v_q;
	logic signed [19:0] base_z_q;
	logic               base_v_q;
	logic signed [19:0] peak_z_q;
	logic               peak_v_q;
	logic [15:0]        frames_q;

	logic [1:0]         n_prev_state;
	logic               n_prev_seen;
	logic signed [19:0] n_pend_z;
	logic               n_pend_v;
	logic signed [19:0] n_base_z;
	logic               n_base_v;
	logic signed [19:0] n_peak_z;
	logic               n_peak_v;
	logic [15:0]        n_frames;

	logic st_known, st_active, st_print, prev_act, prev_print;
	logic started, ended, frame, rebase;
	logic z_ok, in_tol, over_jump, below_base, inside_delta, above_peak;
	logic signed [21:0] z_ext, pend_ext, base_ext, diff, jump_ext, delta_ext;
	logic [21:0]        diff_abs;

	// state decode
	assign st_known   = smp.printer_state <= plftrg_pkg::ST_ATTENTION;
	assign st_active  = (smp.printer_state >= plftrg_pkg::ST_PRINTING) && st_known;
	assign st_print   = smp.printer_state == plftrg_pkg::ST_PRINTING;
	assign prev_act   = prev_seen_q && (prev_state_q != plftrg_pkg::ST_OTHER[1:0]);
	assign prev_print = prev_seen_q && (prev_state_q == plftrg_pkg::ST_PRINTING[1:0]);
	assign started    = !prev_act && st_print;
	assign ended      = prev_act && !st_active;

	// z window and tolerance compare
	assign z_ok      = smp.z_present && (smp.z_um >= cfg.z_min_um) && (smp.z_um <= cfg.z_max_um);
	assign z_ext     = {{2{smp.z_um[19]}}, smp.z_um};
	assign pend_ext  = {{2{pend_z_q[19]}}, pend_z_q};
	assign base_ext  = {{2{base_z_q[19]}}, base_z_q};
	assign diff      = z_ext - pend_ext;
	assign diff_abs  = diff[21] ? 22'(-diff) : 22'(diff);
	assign in_tol    = diff_abs <= {6'd0, cfg.confirm_tol_um};
	assign jump_ext  = $signed({3'd0, cfg.max_jump_um});
	assign delta_ext = $signed({6'd0, cfg.layer_delta_um});

	// baseline compares
	assign over_jump    = z_ext > (base_ext + jump_ext);
	assign below_base   = z_ext < (base_ext - delta_ext);
	assign inside_delta = z_ext < (base_ext + delta_ext);
	assign above_peak   = smp.z_um > peak_z_q;

	// single pass over one sample
	always_comb begin
		n_prev_state = prev_state_q;
		n_prev_seen  = prev_seen_q;
		n_pend_z     = pend_z_q;
		n_pend_v     = pend_v_q;
		n_base_z     = base_z_q;
		n_base_v     = base_v_q;
		n_peak_z     = peak_z_q;
		n_peak_v     = peak_v_q;
		n_frames     = frames_q;
		frame        = 1'b0;
		rebase       = 1'b0;
		res          = '0;

		if (st_known) begin
			if (cfg.layer_frame_mode) begin
				// entering printing starts a fresh session
				if (st_print && !prev_print) begin
					n_pend_v = 1'b0;
					n_base_v = 1'b0;
					n_peak_v = 1'b0;
					n_frames = '0;
				end
				if (!st_print) begin
					n_pend_v = 1'b0;
					if (!smp.recording) begin
						n_base_v = 1'b0;
						n_frames = '0;
					end
				end else if (z_ok && smp.recording) begin
					n_pend_z = smp.z_um;
					n_pend_v = 1'b1;
					// confirmed sample against the baseline
					if (n_pend_v && pend_v_q && in_tol && !(st_print && !prev_print)) begin
						frame = 1'b1;
						if (n_base_v) begin
							if (over_jump) begin
								frame = 1'b0;
							end else if (below_base) begin
								rebase = 1'b1;
							end else if (inside_delta) begin
								frame = 1'b0;
							end
						end
						if (frame) begin
							n_base_z = smp.z_um;
							n_base_v = 1'b1;
							if (!n_peak_v || above_peak) begin
								n_peak_z = smp.z_um;
								n_peak_v = 1'b1;
							end
							if (n_frames != plftrg_pkg::FRAMES_MAX) begin
								n_frames = n_frames + 16'd1;
							end
						end
					end
				end
			end

			if (cfg.trigger_on_print) begin
				if (started) begin
					res.start_timelapse = !smp.recording;
				end else if (ended) begin
					res.stop_timelapse = smp.recording;
				end
			end
			if (cfg.upload_follow_print) begin
				if (ended) begin
					res.upload_off = 1'b1;
				end else if (started) begin
					res.upload_on = 1'b1;
				end
			end
			n_prev_state = smp.printer_state[1:0];
			n_prev_seen  = 1'b1;
		end

		res.frame_trigger   = frame;
		res.rebaselined     = frame && rebase;
		res.frame_count     = n_frames;
		res.peak_layer_z_um = n_peak_v ? n_peak_z : 20'sd0;
	end

	// state update on each sample, mode write drops history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_state_q <= plftrg_pkg::ST_OTHER[1:0];
			prev_seen_q  <= 1'b0;
			pend_z_q     <= '0;
			pend_v_q     <= 1'b0;
			base_z_q     <= '0;
			base_v_q     <= 1'b0;
			peak_z_q     <= '0;
			peak_v_q     <= 1'b0;
			frames_q     <= '0;
		end else if (mode_clr) begin
			pend_z_q <= '0;
			pend_v_q <= 1'b0;
			base_z_q <= '0;
			base_v_q <= 1'b0;
		end else if (step_en) begin
			prev_state_q <= n_prev_state;
			prev_seen_q  <= n_prev_seen;
			pend_z_q     <= n_pend_z;
			pend_v_q     <= n_pend_v;
			base_z_q     <= n_base_z;
			base_v_q     <= n_base_v;
			peak_z_q     <= n_peak_z;
			peak_v_q     <= n_peak_v;
			frames_q     <= n_frames;
		end
	end

endmodule
